// ===== src/rtc_pkg.sv =====
`default_nettype none

package rtc_pkg;

  localparam int BURST_BYTES_DEF = 8;
  localparam int CMD_BITS        = 8;
  localparam int ENABLE_BITS     = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_ENABLE = 2'd3;

  localparam logic [1:0] REG_READ_CMD    = 2'd0;
  localparam logic [1:0] REG_WRITE_CMD   = 2'd1;
  localparam logic [1:0] REG_PROTECT_CMD = 2'd2;

  localparam logic [7:0] READ_CMD_RST    = 8'hbf;
  localparam logic [7:0] WRITE_CMD_RST   = 8'hbe;
  localparam logic [7:0] PROTECT_CMD_RST = 8'h8e;

  localparam logic [7:0] SECONDS_MAX  = 8'h59;
  localparam logic [7:0] DEF_SECONDS  = 8'h00;
  localparam logic [7:0] DEF_MINUTES  = 8'h00;
  localparam logic [7:0] DEF_HOURS    = 8'h12;
  localparam logic [7:0] DEF_DATE     = 8'h01;
  localparam logic [7:0] DEF_MONTH    = 8'h01;
  localparam logic [7:0] DEF_WEEKDAY  = 8'h04;
  localparam logic [7:0] DEF_YEAR     = 8'h99;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] write_bytes;
    logic        data_pin_in;
  } rtc_cmd_t;

  typedef struct packed {
    logic        reset_pin;
    logic        clock_pin;
    logic        data_pin_out;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [63:0] read_bytes;
    logic        clock_stopped;
  } rtc_rsp_t;

endpackage

`default_nettype wire

// ===== src/rtc_chan_if.sv =====
`default_nettype none

interface rtc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/three_wire_rtc_burst_master.sv =====
// three-wire real-time-clock burst master, stepped by transactions on cmd
// cmd: one transaction per tick; operation 0 is a plain tick, 1 starts a
//   burst read, 2 a burst write of write_bytes, 3 a write enable. a start
//   while a transfer runs is handled as a plain tick.
// rsp: exactly one transaction per cmd transaction, carrying the pin levels
//   after that tick, busy, the done pulse, the last read result and the
//   stopped flag.
// each cmd transaction is processed combinationally and its rsp registered;
//   a new cmd can be taken every cycle while the skid entry is empty.
// each serial bit spends two ticks (clock low, clock high); a transfer is a
//   start tick, 2 * (8 + 8 * BURST_BYTES) bit ticks (32 for write enable)
//   and one finishing tick.
// a two-entry output buffer holds results while rsp is stalled; cmd.ready
//   drops only when both entries are full, so no tick is lost.
// reset (rst, synchronous) idles the pins: chip enable low, clock high,
//   data high and driven; command registers return to their defaults.
// cfg_we/cfg_index/cfg_data write the read, write and protect command bytes.
`default_nettype none

module three_wire_rtc_burst_master
  import rtc_pkg::*;
#(
  parameter int BURST_BYTES = BURST_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  rtc_chan_if.sink        cmd,
  rtc_chan_if.source      rsp
);

  localparam int BURST_BITS = 8 * BURST_BYTES;
  localparam int CNT_W      = $clog2(CMD_BITS + BURST_BITS + 1);
  localparam logic [CNT_W-1:0] XFER_BITS   = CNT_W'(CMD_BITS + BURST_BITS);
  localparam logic [CNT_W-1:0] ENABLE_LAST = CNT_W'(ENABLE_BITS);
  localparam logic [CNT_W-1:0] CMD_LAST    = CNT_W'(CMD_BITS);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_READ   = 4'b0010,
    MODE_WRITE  = 4'b0100,
    MODE_ENABLE = 4'b1000
  } mode_t;

  logic [7:0] read_command;
  logic [7:0] write_command;
  logic [7:0] protect_command;

  mode_t                 mode, mode_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic                  clock_phase, clock_phase_next;
  logic [7:0]            command_shift, command_shift_next;
  logic [BURST_BITS-1:0] data_shift, data_shift_next;
  logic                  pin_rst, pin_rst_next;
  logic                  pin_clk, pin_clk_next;
  logic                  pin_dat, pin_dat_next;
  logic                  pin_drv, pin_drv_next;
  logic                  stopped_flag, stopped_flag_next;
  logic [BURST_BITS-1:0] last_read, last_read_next;
  logic                  done_next;

  logic [CNT_W-1:0]      total_bits;
  logic [63:0]           shift_wide;
  logic [63:0]           default_time;

  rtc_rsp_t rsp_data, skid_data, result;
  logic     rsp_valid, skid_valid;
  logic     accept;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !skid_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.payload = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_command    <= READ_CMD_RST;
      write_command   <= WRITE_CMD_RST;
      protect_command <= PROTECT_CMD_RST;
    end else if (cfg_we) begin
      priority if (cfg_index == REG_READ_CMD) begin
        read_command <= cfg_data;
      end else if (cfg_index == REG_WRITE_CMD) begin
        write_command <= cfg_data;
      end else if (cfg_index == REG_PROTECT_CMD) begin
        protect_command <= cfg_data;
      end else begin
        read_command <= read_command;
      end
    end
  end

  assign total_bits   = (mode == MODE_ENABLE) ? ENABLE_LAST : XFER_BITS;
  assign shift_wide   = 64'(data_shift);
  assign default_time = {shift_wide[63:56], DEF_YEAR, DEF_WEEKDAY, DEF_MONTH, DEF_DATE,
                         DEF_HOURS, DEF_MINUTES, DEF_SECONDS};

  always_comb begin
    mode_next          = mode;
    bit_count_next     = bit_count;
    clock_phase_next   = clock_phase;
    command_shift_next = command_shift;
    data_shift_next    = data_shift;
    pin_rst_next       = pin_rst;
    pin_clk_next       = pin_clk;
    pin_dat_next       = pin_dat;
    pin_drv_next       = pin_drv;
    stopped_flag_next  = stopped_flag;
    last_read_next     = last_read;
    done_next          = 1'b0;

    if (mode == MODE_IDLE) begin
      if (cmd.payload.operation != OP_TICK) begin
        bit_count_next   = '0;
        clock_phase_next = 1'b0;
        pin_rst_next     = 1'b1;
        pin_clk_next     = 1'b0;
        pin_dat_next     = 1'b0;
        pin_drv_next     = 1'b1;
        priority if (cmd.payload.operation == OP_READ) begin
          mode_next          = MODE_READ;
          command_shift_next = read_command;
          data_shift_next    = '0;
        end else if (cmd.payload.operation == OP_WRITE) begin
          mode_next          = MODE_WRITE;
          command_shift_next = write_command;
          data_shift_next    = cmd.payload.write_bytes[BURST_BITS-1:0];
        end else begin
          mode_next          = MODE_ENABLE;
          command_shift_next = protect_command;
          data_shift_next    = '0;
        end
      end
    end else if (!clock_phase) begin
      if (bit_count >= total_bits) begin
        if (mode == MODE_READ) begin
          if (data_shift[7:0] > SECONDS_MAX) begin
            last_read_next    = default_time[BURST_BITS-1:0];
            stopped_flag_next = 1'b1;
          end else begin
            last_read_next    = data_shift;
            stopped_flag_next = 1'b0;
          end
        end
        mode_next      = MODE_IDLE;
        bit_count_next = '0;
        pin_rst_next   = 1'b0;
        pin_clk_next   = 1'b1;
        pin_dat_next   = 1'b1;
        pin_drv_next   = 1'b1;
        done_next      = 1'b1;
      end else begin
        pin_rst_next = 1'b1;
        pin_clk_next = 1'b0;
        if (bit_count < CMD_LAST) begin
          pin_dat_next       = command_shift[0];
          pin_drv_next       = 1'b1;
          command_shift_next = {1'b0, command_shift[7:1]};
        end else if (mode == MODE_READ) begin
          pin_dat_next = 1'b0;
          pin_drv_next = 1'b0;
        end else begin
          pin_dat_next    = data_shift[0];
          pin_drv_next    = 1'b1;
          data_shift_next = {1'b0, data_shift[BURST_BITS-1:1]};
        end
        clock_phase_next = 1'b1;
      end
    end else begin
      // read data arrives lsb first, so shift in at the top
      if (mode == MODE_READ && bit_count >= CMD_LAST) begin
        data_shift_next = {cmd.payload.data_pin_in, data_shift[BURST_BITS-1:1]};
      end
      pin_clk_next     = 1'b1;
      bit_count_next   = bit_count + CNT_W'(1);
      clock_phase_next = 1'b0;
    end
  end

  always_comb begin
    result.reset_pin     = pin_rst_next;
    result.clock_pin     = pin_clk_next;
    result.data_pin_out  = pin_dat_next;
    result.data_drive    = pin_drv_next;
    result.busy_res      = (mode_next != MODE_IDLE);
    result.done_res      = done_next;
    result.read_bytes    = 64'(last_read_next);
    result.clock_stopped = stopped_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      bit_count     <= '0;
      clock_phase   <= 1'b0;
      command_shift <= '0;
      data_shift    <= '0;
      pin_rst       <= 1'b0;
      pin_clk       <= 1'b1;
      pin_dat       <= 1'b1;
      pin_drv       <= 1'b1;
      stopped_flag  <= 1'b0;
      last_read     <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      bit_count     <= bit_count_next;
      clock_phase   <= clock_phase_next;
      command_shift <= command_shift_next;
      data_shift    <= data_shift_next;
      pin_rst       <= pin_rst_next;
      pin_clk       <= pin_clk_next;
      pin_dat       <= pin_dat_next;
      pin_drv       <= pin_drv_next;
      stopped_flag  <= stopped_flag_next;
      last_read     <= last_read_next;
    end
  end

  // two-entry result buffer: output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || rsp.ready) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp.ready) begin
      if (skid_valid) begin
        rsp_data <= skid_data;
      end else begin
        rsp_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

`default_nettype wire
